[rtl/word_ladder_bfs_top_assert.svh]
// ----------------------------------------------------------------------------
// Word ladder search assertion macros
// Shorthand for the concurrent assertions of the port checker.
// ----------------------------------------------------------------------------
`ifndef WORD_LADDER_BFS_TOP_ASSERT_SVH
`define WORD_LADDER_BFS_TOP_ASSERT_SVH

// Same-cycle implication, reset masks the check.
`define WLB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset masks the check.
`define WLB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/wlb_pkg.sv]
// ----------------------------------------------------------------------------
// Word ladder search package
// Sizes, codes, types and word compare functions shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package wlb_pkg;

   localparam int MAX_WORDS  = 64;
   localparam int MAX_CHARS  = 8;
   localparam int CHAR_W     = 8;
   localparam int WORD_W     = 64;
   localparam int IDX_W      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int CNT_W      = $clog2(MAX_WORDS + 1);
   localparam int LEN_W      = $clog2(MAX_WORDS + 2);
   localparam int QENT_W     = IDX_W + LEN_W;
   localparam int WLEN_W     = 4;
   localparam int LADDER_W   = 7;
   localparam int ACT_W      = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [WLEN_W-1:0] WORD_LENGTH_RESET = WLEN_W'(3);

   // Action codes
   localparam logic [ACT_W-1:0] ACT_SET_BEGIN = 2'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RUN       = 2'd2;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_WORD_LENGTH = REG_IDX_W'(0);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POP,
      ST_FETCH,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [IDX_W-1:0] idx;
   } qent_type;

   // One bit per character position that takes part and differs.
   function automatic logic [MAX_CHARS-1:0] byte_diff(input logic [WORD_W-1:0] a,
                                                      input logic [WORD_W-1:0] b,
                                                      input logic [WLEN_W-1:0] wl);
      logic [MAX_CHARS-1:0] d;
      logic [WLEN_W-1:0]    n;
      n = (wl > WLEN_W'(MAX_CHARS)) ? WLEN_W'(MAX_CHARS) : wl;
      for (int k = 0; k < MAX_CHARS; k++) begin
         d[k] = (WLEN_W'(k) < n) && (a[k*CHAR_W +: CHAR_W] != b[k*CHAR_W +: CHAR_W]);
      end
      return d;
   endfunction

   function automatic logic is_adjacent(input logic [WORD_W-1:0] a,
                                        input logic [WORD_W-1:0] b,
                                        input logic [WLEN_W-1:0] wl);
      logic [MAX_CHARS-1:0] d;
      d = byte_diff(a, b, wl);
      return (d & (d - MAX_CHARS'(1))) == '0;
   endfunction

   function automatic logic words_equal(input logic [WORD_W-1:0] a,
                                        input logic [WORD_W-1:0] b,
                                        input logic [WLEN_W-1:0] wl);
      return byte_diff(a, b, wl) == '0;
   endfunction

endpackage

`default_nettype wire

[rtl/wlb_if.sv]
// ----------------------------------------------------------------------------
// Word ladder search channels
// Valid/ready channels for word items and search results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wlb_req_if;
   logic                      valid;
   logic                      ready;
   logic [wlb_pkg::ACT_W-1:0]  action;
   logic [wlb_pkg::WORD_W-1:0] word_chars;

   modport source (output valid, output action, output word_chars, input ready);
   modport sink   (input valid, input action, input word_chars, output ready);
endinterface

interface wlb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wlb_pkg::LADDER_W-1:0] ladder_length;
   logic                        list_overflowed;

   modport source (output valid, output ladder_length, output list_overflowed, input ready);
   modport sink   (input valid, input ladder_length, input list_overflowed, output ready);
endinterface

`default_nettype wire

[rtl/word_ladder_bfs_top.sv]
// ----------------------------------------------------------------------------
// Word ladder search
// Breadth-first shortest word ladder over a loaded word list.
// ----------------------------------------------------------------------------
// Begin-word and append items are taken while idle. A run item walks the
// word store through its single read port: it scans the whole list, then
// each dequeued word passes through queue and store reads (pop, fetch,
// check) before its own scan, and an empty queue ends the search.
// The result waits in an output register, and no transaction is taken
// until it has been accepted.
`default_nettype none

module word_ladder_bfs_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   wlb_req_if.sink                               req_ch,
   wlb_rsp_if.source                             rsp_ch,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [wlb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [wlb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [wlb_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready
);

   logic [wlb_pkg::WLEN_W-1:0] word_length;

   wlb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .word_length (word_length)
   );

   wlb_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .word_length (word_length),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

endmodule

`default_nettype wire

[rtl/wlb_ram.sv]
// ----------------------------------------------------------------------------
// Word ladder search RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wlb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                    clock,
   input  wire logic                    we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]        wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/wlb_csr.sv]
// ----------------------------------------------------------------------------
// Word ladder search register port
// APB-style access to the word length register.
// ----------------------------------------------------------------------------
`default_nettype none

module wlb_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [wlb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [wlb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [wlb_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready,
   output logic      [wlb_pkg::WLEN_W-1:0]       word_length
);

   logic [wlb_pkg::WLEN_W-1:0]    word_length_ff;
   logic [wlb_pkg::WLEN_W-1:0]    word_length_in;
   logic [wlb_pkg::REG_IDX_W-1:0] reg_idx;
   logic                          wr_en;

   assign reg_idx = paddr[wlb_pkg::CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      word_length_in = word_length_ff;
      if (wr_en && (reg_idx == wlb_pkg::REG_WORD_LENGTH)) begin
         word_length_in = pwdata[wlb_pkg::WLEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_length_ff <= wlb_pkg::WORD_LENGTH_RESET;
      end else begin
         word_length_ff <= word_length_in;
      end
   end

   assign prdata      = (reg_idx == wlb_pkg::REG_WORD_LENGTH) ?
                        wlb_pkg::CSR_DATA_W'(word_length_ff) : '0;
   assign pready      = 1'b1;
   assign word_length = word_length_ff;

endmodule

`default_nettype wire

[rtl/wlb_engine.sv]
// ----------------------------------------------------------------------------
// Word ladder search engine
// Word store, search queue, visited flags and the search sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module wlb_engine (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [wlb_pkg::WLEN_W-1:0] word_length,
   wlb_req_if.sink                         req_ch,
   wlb_rsp_if.source                       rsp_ch
);

   wlb_pkg::state_type state_ff, state_in;

   logic [wlb_pkg::WORD_W-1:0]   begin_ff, begin_in;
   logic [wlb_pkg::WORD_W-1:0]   end_ff, end_in;
   logic [wlb_pkg::WORD_W-1:0]   cur_word_ff, cur_word_in;
   logic [wlb_pkg::LEN_W-1:0]    cur_len_ff, cur_len_in;
   logic [wlb_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [wlb_pkg::CNT_W-1:0]    scan_addr_ff, scan_addr_in;
   logic [wlb_pkg::CNT_W-1:0]    head_ff, head_in;
   logic [wlb_pkg::CNT_W-1:0]    tail_ff, tail_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [wlb_pkg::IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                         ovf_ff, ovf_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [wlb_pkg::LADDER_W-1:0] rsp_len_ff, rsp_len_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;

   logic                         req_fire;
   logic                         rsp_fire;
   logic                         scan_more;
   logic                         push;
   logic                         end_hit;
   logic                         queue_empty;

   logic                         st_we;
   logic [wlb_pkg::IDX_W-1:0]    st_waddr;
   logic [wlb_pkg::WORD_W:0]     st_wdata;
   logic [wlb_pkg::IDX_W-1:0]    st_raddr;
   logic [wlb_pkg::WORD_W:0]     st_rdata;
   logic                         q_we;
   logic [wlb_pkg::IDX_W-1:0]    q_raddr;
   wlb_pkg::qent_type            q_wdata;
   wlb_pkg::qent_type            q_rdata;

   // Each store entry carries its visited flag above the word. Appends write
   // while idle; the visited mark writes back in the cycle after the scan read,
   // and queue writes happen only while scanning, so no read and write of one
   // entry ever overlap.
   wlb_ram #(
      .WIDTH (wlb_pkg::WORD_W + 1),
      .DEPTH (wlb_pkg::MAX_WORDS)
   ) u_word_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   wlb_ram #(
      .WIDTH (wlb_pkg::QENT_W),
      .DEPTH (wlb_pkg::MAX_WORDS)
   ) u_search_queue (
      .clock (clock),
      .we    (q_we),
      .waddr (tail_ff[wlb_pkg::IDX_W-1:0]),
      .wdata (q_wdata),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   assign req_ch.ready = (state_ff == wlb_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_valid_ff && rsp_ch.ready;
   assign scan_more    = scan_addr_ff < count_ff;
   assign queue_empty  = head_ff == tail_ff;
   assign push         = (state_ff == wlb_pkg::ST_SCAN) && rd_vld_ff &&
                         !st_rdata[wlb_pkg::WORD_W] &&
                         wlb_pkg::is_adjacent(cur_word_ff, st_rdata[wlb_pkg::WORD_W-1:0],
                                              word_length);
   assign end_hit      = wlb_pkg::words_equal(st_rdata[wlb_pkg::WORD_W-1:0], end_ff,
                                              word_length);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wlb_pkg::ST_IDLE: begin
            if (req_fire && (req_ch.action == wlb_pkg::ACT_RUN)) begin
               state_in = wlb_pkg::ST_SCAN;
            end
         end
         wlb_pkg::ST_SCAN: begin
            if (!scan_more) begin
               state_in = wlb_pkg::ST_POP;
            end
         end
         wlb_pkg::ST_POP: begin
            state_in = queue_empty ? wlb_pkg::ST_IDLE : wlb_pkg::ST_FETCH;
         end
         wlb_pkg::ST_FETCH: begin
            state_in = wlb_pkg::ST_CHECK;
         end
         wlb_pkg::ST_CHECK: begin
            state_in = end_hit ? wlb_pkg::ST_IDLE : wlb_pkg::ST_SCAN;
         end
         default: begin
            state_in = wlb_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control
   always_comb begin
      begin_in     = begin_ff;
      end_in       = end_ff;
      cur_word_in  = cur_word_ff;
      cur_len_in   = cur_len_ff;
      count_in     = count_ff;
      scan_addr_in = scan_addr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      st_we        = 1'b0;
      st_waddr     = count_ff[wlb_pkg::IDX_W-1:0];
      st_wdata     = {1'b0, req_ch.word_chars};
      st_raddr     = scan_addr_ff[wlb_pkg::IDX_W-1:0];
      q_we         = 1'b0;
      q_raddr      = head_ff[wlb_pkg::IDX_W-1:0];
      q_wdata      = '{len: cur_len_ff + wlb_pkg::LEN_W'(1), idx: rd_idx_ff};

      case (state_ff)
         wlb_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.action)
                  wlb_pkg::ACT_SET_BEGIN: begin
                     begin_in = req_ch.word_chars;
                  end
                  wlb_pkg::ACT_APPEND: begin
                     // A fresh append clears the entry's visited flag.
                     if (count_ff < wlb_pkg::CNT_W'(wlb_pkg::MAX_WORDS)) begin
                        st_we    = 1'b1;
                        count_in = count_ff + wlb_pkg::CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  wlb_pkg::ACT_RUN: begin
                     // The begin word seeds the first scan at ladder length one.
                     end_in       = req_ch.word_chars;
                     cur_word_in  = begin_ff;
                     cur_len_in   = wlb_pkg::LEN_W'(1);
                     scan_addr_in = '0;
                     head_in      = '0;
                     tail_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         wlb_pkg::ST_SCAN: begin
            rd_vld_in = scan_more;
            rd_idx_in = scan_addr_ff[wlb_pkg::IDX_W-1:0];
            if (scan_more) begin
               scan_addr_in = scan_addr_ff + wlb_pkg::CNT_W'(1);
            end
            // Mark visited when queued: write the word back with its flag set.
            if (push) begin
               q_we     = 1'b1;
               st_we    = 1'b1;
               st_waddr = rd_idx_ff;
               st_wdata = {1'b1, st_rdata[wlb_pkg::WORD_W-1:0]};
               tail_in  = tail_ff + wlb_pkg::CNT_W'(1);
            end
         end
         wlb_pkg::ST_POP: begin
            if (!queue_empty) begin
               head_in = head_ff + wlb_pkg::CNT_W'(1);
            end
         end
         wlb_pkg::ST_FETCH: begin
            st_raddr   = q_rdata.idx;
            cur_len_in = q_rdata.len;
         end
         wlb_pkg::ST_CHECK: begin
            cur_word_in  = st_rdata[wlb_pkg::WORD_W-1:0];
            scan_addr_in = '0;
         end
         default: begin
         end
      endcase

      // Publish the result and drop the list and overflow mark.
      if (((state_ff == wlb_pkg::ST_POP) && queue_empty) ||
          ((state_ff == wlb_pkg::ST_CHECK) && end_hit)) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = (state_ff == wlb_pkg::ST_POP) ? '0 : wlb_pkg::LADDER_W'(cur_len_ff);
         rsp_ovf_in   = ovf_ff;
         count_in     = '0;
         ovf_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wlb_pkg::ST_IDLE;
         begin_ff     <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         begin_ff     <= begin_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff       <= end_in;
      cur_word_ff  <= cur_word_in;
      cur_len_ff   <= cur_len_in;
      scan_addr_ff <= scan_addr_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.ladder_length   = rsp_len_ff;
   assign rsp_ch.list_overflowed = rsp_ovf_ff;

endmodule

`default_nettype wire

[rtl/wlb_checker.sv]
// ----------------------------------------------------------------------------
// Word ladder search port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "word_ladder_bfs_top_assert.svh"

module wlb_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              pready,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [wlb_pkg::ACT_W-1:0]         req_action,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [wlb_pkg::LADDER_W-1:0]      rsp_ladder_length,
   input wire logic                              rsp_list_overflowed
);

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   `WLB_ASSERT_IMP(a_pready_high, clock, reset, 1'b1, pready, "pready dropped")

   // The shortest ladder has at least two words, so one never shows.
   `WLB_ASSERT_IMP(a_len_not_one, clock, reset, rsp_valid, rsp_ladder_length != wlb_pkg::LADDER_W'(1), "ladder length of one")

   `WLB_ASSERT_NXT(a_load_no_result, clock, reset, req_fire && (req_action != wlb_pkg::ACT_RUN), !$rose(rsp_valid), "result after a load transaction")

   `WLB_ASSERT_NXT(a_run_busy, clock, reset, req_fire && (req_action == wlb_pkg::ACT_RUN), !req_ready, "input open during search")

   `WLB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ladder_length) && $stable(rsp_list_overflowed), "stalled result changed")

endmodule

bind word_ladder_bfs_top wlb_checker u_wlb_checker (
   .clock               (clock),
   .reset               (reset),
   .pready              (pready),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .req_action          (req_ch.action),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_ladder_length   (rsp_ch.ladder_length),
   .rsp_list_overflowed (rsp_ch.list_overflowed)
);

`default_nettype wire
